@@ sv/trgp_pkg.sv @@
// Shared types and constants for the 9-dot text row glyph packer.
// Used by every module of the block; depends on nothing.
package trgp_pkg;

	localparam int TEXT_COLUMNS = 80;
	localparam int CELL_ROWS    = 19;
	localparam int FONT_CHARS   = 256;
	localparam int GLYPH_TOP    = 5;
	localparam int GLYPH_ROWS   = 8;
	localparam int FONT_DEPTH   = FONT_CHARS * GLYPH_ROWS;
	localparam int FONT_AW      = $clog2(FONT_DEPTH);
	localparam int COL_W        = 7;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] char_code;
		logic [4:0] pixel_row;
		logic [7:0] font_data;
		logic [5:0] screen_line;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic [6:0] byte_index;
		logic [4:0] row_out;
		logic [5:0] line_out;
		logic       last_of_row;
	} out_word_t;

	// One rendered character: one or two output words.
	typedef struct packed {
		out_word_t w0;
		out_word_t w1;
		logic      two;
	} pair_t;

endpackage

@@ sv/trgp_font_store.sv @@
// Font memory: one write port, one read port with registered read data.
// Depends on trgp_pkg for depth and address width.
module trgp_font_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [trgp_pkg::FONT_AW-1:0] wr_addr,
	input  logic [7:0]                  wr_data,
	input  logic                        rd_en,
	input  logic [trgp_pkg::FONT_AW-1:0] rd_addr,
	output logic [7:0]                  rd_data
);

	logic [7:0] mem [trgp_pkg::FONT_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/trgp_packer.sv @@
// Packs 9-dot cells into bytes; holds the previous glyph and the column count.
// Depends on trgp_pkg for word types and the row length.
module trgp_packer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [7:0]              glyph,
	input  logic [4:0]              row,
	input  logic [5:0]              line,
	output trgp_pkg::pair_t         pair
);

	logic [7:0]                  prev_q;
	logic [trgp_pkg::COL_W-1:0]  col_q;
	logic [2:0]                  j;
	logic [3:0]                  grp;
	logic [6:0]                  base;
	logic                        last;
	logic [7:0]                  first_byte;
	logic [7:0]                  second_byte;
	logic                        has_second;
	trgp_pkg::out_word_t         first_w;
	trgp_pkg::out_word_t         second_w;

	assign j    = col_q[2:0];
	assign grp  = col_q[6:3];
	assign base = 7'({grp, 3'b000}) + 7'(grp) + 7'(j);
	assign last = (col_q >= trgp_pkg::COL_W'(trgp_pkg::TEXT_COLUMNS - 1));

	always_comb begin
		first_byte  = 8'(glyph >> (4'(j) + 4'd1));
		second_byte = 8'(glyph << (4'd7 - 4'(j)));
		has_second  = last;
		if (j != 3'd0) begin
			first_byte = 8'(prev_q << (4'd8 - 4'(j))) | first_byte;
		end
		if (j == 3'd6) begin
			second_byte = 8'(glyph << 1);
			has_second  = 1'b1;
		end else if (j == 3'd7) begin
			second_byte = glyph;
			has_second  = 1'b1;
		end
	end

	always_comb begin
		first_w.pixel_byte   = first_byte;
		first_w.byte_index   = base;
		first_w.row_out      = row;
		first_w.line_out     = line;
		first_w.last_of_row  = 1'b0;
		second_w.pixel_byte  = second_byte;
		second_w.byte_index  = base + 7'd1;
		second_w.row_out     = row;
		second_w.line_out    = line;
		second_w.last_of_row = last;
		if (j == 3'd7) begin
			pair.w0  = second_w;
			pair.w1  = second_w;
			pair.two = 1'b0;
		end else begin
			pair.w0  = first_w;
			pair.w1  = second_w;
			pair.two = has_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			col_q  <= '0;
		end else if (advance) begin
			prev_q <= glyph;
			col_q  <= last ? '0 : col_q + trgp_pkg::COL_W'(1);
		end
	end

endmodule

@@ sv/trgp_out_stage.sv @@
// Two-word output buffer: takes a rendered pair, hands words out one at a time.
// Depends on trgp_pkg for word types.
module trgp_out_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  trgp_pkg::pair_t         pair,
	output logic                    free,
	output logic                    valid,
	input  logic                    stall,
	output trgp_pkg::out_word_t     word
);

	logic                has0_q;
	logic                has1_q;
	trgp_pkg::out_word_t w0_q;
	trgp_pkg::out_word_t w1_q;
	logic                pop;

	assign pop   = has0_q && !stall;
	assign free  = !has0_q || (pop && !has1_q);
	assign valid = has0_q;
	assign word  = w0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has0_q <= 1'b0;
			has1_q <= 1'b0;
		end else if (load) begin
			has0_q <= 1'b1;
			has1_q <= pair.two;
		end else if (pop) begin
			has0_q <= has1_q;
			has1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			w0_q <= pair.w0;
			w1_q <= pair.w1;
		end else if (pop) begin
			w0_q <= w1_q;
		end
	end

endmodule

@@ sv/text_row_glyph_packer_9dot_unit.sv @@
// Top level of the 9-dot text row glyph packer: input handshake, font read stage.
// Depends on trgp_pkg, trgp_font_store, trgp_packer and trgp_out_stage.
//
//   channel   dir   handshake              word
//   item      in    item_valid/item_stall  trgp_pkg::in_word_t
//   result    out   result_valid/...stall  trgp_pkg::out_word_t
//
// A load word writes the font store at accept if its pixel row is below GLYPH_ROWS;
// no load word yields a result. A render word reads the font store at accept; the
// read stage loads its pair into the output buffer when that is empty or its last word
// is leaving; result words leave the port one at a time unless stalled.
// Reset empties the read stage and output buffer, zeroes previous glyph and column count.
// A stalled result holds; the read stage waits and then stalls the item port.
module text_row_glyph_packer_9dot_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  trgp_pkg::in_word_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output trgp_pkg::out_word_t  result
);

	logic                         item_acc;
	logic                         is_render;
	logic                         row_is_glyph;
	logic                         code_in_font;
	logic [4:0]                   glyph_row;
	logic [trgp_pkg::FONT_AW-1:0] font_addr;
	logic                         wr_en;
	logic                         rd_en;
	logic [7:0]                   rd_data;

	logic                         valid_s1;
	logic                         blank_s1;
	logic [4:0]                   row_s1;
	logic [5:0]                   line_s1;
	logic                         adv_s1;
	logic [7:0]                   glyph_s1;

	logic                         out_free;
	trgp_pkg::pair_t              pair;

	// Advance the read stage only when the output buffer can take a full pair.
	assign adv_s1     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !adv_s1;
	assign item_acc   = item_valid && !item_stall;
	assign is_render  = (item.mode == trgp_pkg::MODE_RENDER);

	assign code_in_font = ({1'b0, item.char_code} < 9'(trgp_pkg::FONT_CHARS));

	// Glyph rows sit in the middle of the cell; everything else is blank.
	assign row_is_glyph =
		(item.pixel_row >= 5'(trgp_pkg::GLYPH_TOP)) &&
		({1'b0, item.pixel_row} < 6'(trgp_pkg::GLYPH_TOP + trgp_pkg::GLYPH_ROWS)) &&
		({1'b0, item.pixel_row} < 6'(trgp_pkg::CELL_ROWS)) &&
		code_in_font;

	// Load rows are given directly; render rows are offset by the top blank band.
	assign glyph_row = is_render ? (item.pixel_row - 5'(trgp_pkg::GLYPH_TOP))
	                             : item.pixel_row;
	assign font_addr = trgp_pkg::FONT_AW'({item.char_code, glyph_row[2:0]});

	assign wr_en = item_acc && !is_render && code_in_font &&
		(item.pixel_row < 5'(trgp_pkg::GLYPH_ROWS));
	assign rd_en = item_acc && is_render;

	trgp_font_store u_font (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (font_addr),
		.wr_data (item.font_data),
		.rd_en   (rd_en),
		.rd_addr (font_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the row metadata next to the font read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			blank_s1 <= !row_is_glyph;
			row_s1   <= item.pixel_row;
			line_s1  <= item.screen_line;
		end
	end

	// Drop the read data on blank rows.
	assign glyph_s1 = blank_s1 ? 8'h00 : rd_data;

	trgp_packer u_packer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv_s1),
		.glyph   (glyph_s1),
		.row     (row_s1),
		.line    (line_s1),
		.pair    (pair)
	);

	trgp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv_s1),
		.pair   (pair),
		.free   (out_free),
		.valid  (result_valid),
		.stall  (result_stall),
		.word   (result)
	);

endmodule
